FILE: sv/sct_pkg.sv
package sct_pkg;

    localparam int MAX_LINE_DEF    = 4096;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int KIND_W  = 4;
    localparam int START_W = 12;
    localparam int LEN_W   = 13;
    localparam int RUN_MAX = 3;
    localparam int CNT_W   = 2;

    typedef enum logic [KIND_W-1:0] {
        TK_WORD    = 4'd0,
        TK_PIPE    = 4'd1,
        TK_OR      = 4'd2,
        TK_BG      = 4'd3,
        TK_AND     = 4'd4,
        TK_IN      = 4'd5,
        TK_OUT     = 4'd6,
        TK_APPEND  = 4'd7,
        TK_ERR     = 4'd8,
        TK_ERR_OUT = 4'd9,
        TK_SEMI    = 4'd10,
        TK_LPAREN  = 4'd11,
        TK_RPAREN  = 4'd12,
        TK_EOF     = 4'd13
    } kind_t;

    // tokens caused by one input beat; a word token is always in slot 0
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        kind_t              kind0;
        kind_t              kind1;
        kind_t              kind2;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        logic               ovf;
    } run_t;

endpackage

FILE: sv/sct_front.sv
module sct_front
    import sct_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       ch_valid,
    output logic       ch_stall,
    input  logic [7:0] ch,
    input  logic       end_of_input,
    input  logic       q_full,
    output logic       push,
    output run_t       run
);

    localparam int PW = $clog2(MAX_LINE + 1);
    localparam int OW = $clog2(MAX_LINE);

    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    typedef enum logic [2:0] {
        M_IDLE,
        M_WORD,
        M_PIPE,
        M_AMP,
        M_GT,
        M_TWO,
        M_ERR,
        M_ERRAMP
    } mode_t;

    typedef struct packed {
        logic sq;
        logic dq;
        logic esc;
    } quote_t;

    typedef struct packed {
        logic   cont;
        quote_t q;
    } word_res_t;

    typedef struct packed {
        logic  emit;
        kind_t kind;
        mode_t mode;
        logic  start_word;
    } idle_res_t;

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c == CH_PIPE || c == CH_LT || c == CH_GT || c == CH_AMP ||
               c == CH_SEMI || c == CH_LPAREN || c == CH_RPAREN;
    endfunction

    function automatic word_res_t word_step(input quote_t q, input logic [7:0] c);
        word_res_t r;
        r.q    = q;
        r.cont = 1'b1;
        if (q.esc) begin
            r.q.esc = 1'b0;
        end
        else if (q.sq) begin
            if (c == CH_SQUOTE)
                r.q.sq = 1'b0;
        end
        else if (c == CH_BSLASH) begin
            r.q.esc = 1'b1;
        end
        else if (q.dq) begin
            if (c == CH_DQUOTE)
                r.q.dq = 1'b0;
        end
        else if (c == CH_SQUOTE) begin
            r.q.sq = 1'b1;
        end
        else if (c == CH_DQUOTE) begin
            r.q.dq = 1'b1;
        end
        else begin
            r.cont = !(is_space(c) || is_op(c));
        end
        return r;
    endfunction

    function automatic idle_res_t idle_step(input logic [7:0] c);
        idle_res_t r;
        r.emit       = 1'b0;
        r.kind       = TK_WORD;
        r.mode       = M_IDLE;
        r.start_word = 1'b0;
        if (is_space(c)) begin
            r.mode = M_IDLE;
        end
        else begin
            case (c)
                CH_PIPE:   r.mode = M_PIPE;
                CH_AMP:    r.mode = M_AMP;
                CH_GT:     r.mode = M_GT;
                CH_LT:     begin r.emit = 1'b1; r.kind = TK_IN;     end
                CH_SEMI:   begin r.emit = 1'b1; r.kind = TK_SEMI;   end
                CH_LPAREN: begin r.emit = 1'b1; r.kind = TK_LPAREN; end
                CH_RPAREN: begin r.emit = 1'b1; r.kind = TK_RPAREN; end
                CH_TWO:    begin r.start_word = 1'b1; r.mode = M_TWO;  end
                default:   begin r.start_word = 1'b1; r.mode = M_WORD; end
            endcase
        end
        return r;
    endfunction

    mode_t           mode_reg, mode_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [OW-1:0]   wb_reg, wb_next;
    quote_t          quote_reg, quote_next;
    logic            ovf_reg, ovf_next;

    logic            accept;
    logic            at_max;
    logic [OW-1:0]   off;
    logic [PW-1:0]   wlen;
    idle_res_t       ir;
    word_res_t       wc_cur;
    word_res_t       wc_fresh;
    logic            run_idle;
    kind_t           kinds [RUN_MAX];
    logic [CNT_W-1:0] cnt;

    assign ch_stall = q_full;
    assign accept   = ch_valid && !q_full;

    assign at_max   = pos_reg == PW'(MAX_LINE);
    assign off      = at_max ? OW'(MAX_LINE - 1) : pos_reg[OW-1:0];
    assign wlen     = (pos_reg > PW'(wb_reg)) ? pos_reg - PW'(wb_reg) : '0;
    assign ir       = idle_step(ch);
    assign wc_cur   = word_step(quote_reg, ch);
    assign wc_fresh = word_step('0, ch);

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        wb_next    = wb_reg;
        quote_next = quote_reg;
        ovf_next   = ovf_reg;
        run_idle   = 1'b0;
        cnt        = '0;
        for (int i = 0; i < RUN_MAX; i++)
            kinds[i] = TK_WORD;

        if (end_of_input) begin
            unique case (mode_reg)
                M_WORD, M_TWO: begin kinds[cnt] = TK_WORD; cnt = cnt + 1'b1; end
                M_PIPE:        begin kinds[cnt] = TK_PIPE; cnt = cnt + 1'b1; end
                M_AMP:         begin kinds[cnt] = TK_BG;   cnt = cnt + 1'b1; end
                M_GT:          begin kinds[cnt] = TK_OUT;  cnt = cnt + 1'b1; end
                M_ERR:         begin kinds[cnt] = TK_ERR;  cnt = cnt + 1'b1; end
                M_ERRAMP:
                begin
                    kinds[cnt] = TK_ERR; cnt = cnt + 1'b1;
                    kinds[cnt] = TK_BG;  cnt = cnt + 1'b1;
                end
                default: ;
            endcase
            kinds[cnt] = TK_EOF;
            cnt        = cnt + 1'b1;
            mode_next  = M_IDLE;
            pos_next   = '0;
            wb_next    = '0;
            quote_next = '0;
            ovf_next   = 1'b0;
        end
        else begin
            if (at_max)
                ovf_next = 1'b1;
            else
                pos_next = pos_reg + 1'b1;

            unique case (mode_reg)
                M_IDLE: run_idle = 1'b1;
                M_WORD:
                begin
                    if (wc_cur.cont) begin
                        quote_next = wc_cur.q;
                    end
                    else begin
                        kinds[cnt] = TK_WORD; cnt = cnt + 1'b1;
                        quote_next = '0;
                        run_idle   = 1'b1;
                    end
                end
                M_PIPE:
                begin
                    mode_next = M_IDLE;
                    if (ch == CH_PIPE) begin
                        kinds[cnt] = TK_OR; cnt = cnt + 1'b1;
                    end
                    else begin
                        kinds[cnt] = TK_PIPE; cnt = cnt + 1'b1;
                        run_idle = 1'b1;
                    end
                end
                M_AMP:
                begin
                    mode_next = M_IDLE;
                    if (ch == CH_AMP) begin
                        kinds[cnt] = TK_AND; cnt = cnt + 1'b1;
                    end
                    else begin
                        kinds[cnt] = TK_BG; cnt = cnt + 1'b1;
                        run_idle = 1'b1;
                    end
                end
                M_GT:
                begin
                    mode_next = M_IDLE;
                    if (ch == CH_GT) begin
                        kinds[cnt] = TK_APPEND; cnt = cnt + 1'b1;
                    end
                    else begin
                        kinds[cnt] = TK_OUT; cnt = cnt + 1'b1;
                        run_idle = 1'b1;
                    end
                end
                M_TWO:
                begin
                    if (ch == CH_GT) begin
                        mode_next = M_ERR;
                    end
                    else if (wc_fresh.cont) begin
                        mode_next  = M_WORD;
                        quote_next = wc_fresh.q;
                    end
                    else begin
                        kinds[cnt] = TK_WORD; cnt = cnt + 1'b1;
                        quote_next = '0;
                        run_idle   = 1'b1;
                    end
                end
                M_ERR:
                begin
                    if (ch == CH_AMP) begin
                        mode_next = M_ERRAMP;
                    end
                    else begin
                        kinds[cnt] = TK_ERR; cnt = cnt + 1'b1;
                        run_idle = 1'b1;
                    end
                end
                M_ERRAMP:
                begin
                    mode_next = M_IDLE;
                    if (ch == CH_ONE) begin
                        kinds[cnt] = TK_ERR_OUT; cnt = cnt + 1'b1;
                    end
                    else begin
                        // broken 2>&: the & is relexed with this char as lookahead
                        kinds[cnt] = TK_ERR; cnt = cnt + 1'b1;
                        if (ch == CH_AMP) begin
                            kinds[cnt] = TK_AND; cnt = cnt + 1'b1;
                        end
                        else begin
                            kinds[cnt] = TK_BG; cnt = cnt + 1'b1;
                            run_idle = 1'b1;
                        end
                    end
                end
                default: mode_next = M_IDLE;
            endcase

            if (run_idle) begin
                if (ir.emit) begin
                    kinds[cnt] = ir.kind; cnt = cnt + 1'b1;
                end
                mode_next = ir.mode;
                if (ir.start_word) begin
                    wb_next    = off;
                    quote_next = wc_fresh.q;
                end
            end
        end
    end

    always_comb
    begin
        run.count = cnt;
        run.kind0 = kinds[0];
        run.kind1 = kinds[1];
        run.kind2 = kinds[2];
        run.start = START_W'(wb_reg);
        run.len   = LEN_W'(wlen);
        run.ovf   = end_of_input ? ovf_reg : ovf_next;
    end

    assign push = accept && (cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= M_IDLE;
            pos_reg   <= '0;
            wb_reg    <= '0;
            quote_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            wb_reg    <= wb_next;
            quote_reg <= quote_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

FILE: sv/sct_queue.sv
module sct_queue
    import sct_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  run_t push_data,
    output logic full,
    input  logic pop,
    output logic empty,
    output run_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    run_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    assign full  = cnt_reg == CW'(DEPTH);
    assign empty = cnt_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: sv/sct_back.sv
module sct_back
    import sct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  run_t               head,
    output logic               pop,
    output logic               token_valid,
    input  logic               token_stall,
    output logic [KIND_W-1:0]  token_kind,
    output logic [START_W-1:0] word_start,
    output logic [LEN_W-1:0]   word_length,
    output logic               overflow,
    output logic               last_of_run
);

    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               valid_reg;
    kind_t              kind_reg;
    logic [START_W-1:0] start_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               ovf_reg;
    logic               last_reg;

    logic               load;
    logic               last;
    kind_t              sel_kind;

    assign load = !empty && (!valid_reg || !token_stall);
    assign last = idx_reg == head.count - 1'b1;
    assign pop  = load && last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_kind = head.kind0;
            2'd1:    sel_kind = head.kind1;
            default: sel_kind = head.kind2;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
            idx_next = last ? '0 : idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else begin
            idx_reg <= idx_next;
            if (load)
                valid_reg <= 1'b1;
            else if (!token_stall)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            kind_reg  <= sel_kind;
            start_reg <= (sel_kind == TK_WORD) ? head.start : '0;
            len_reg   <= (sel_kind == TK_WORD) ? head.len : '0;
            ovf_reg   <= head.ovf;
            last_reg  <= last;
        end
    end

    assign token_valid = valid_reg;
    assign token_kind  = kind_reg;
    assign word_start  = start_reg;
    assign word_length = len_reg;
    assign overflow    = ovf_reg;
    assign last_of_run = last_reg;

endmodule

FILE: sv/shell_command_tokenizer_unit.sv
// Streaming command-line lexer. One character (or an end-of-input beat) is taken per cycle
// while ch_stall is low; each beat yields zero to three tokens (pipe/or/&/&&, redirections,
// ; ( ), words as start offset plus raw length, EOF). The lexer state updates in the cycle a
// beat is taken, its tokens go into a queue of QUEUE_DEPTH entries (2 by default), and a
// serializer drives one token per cycle, while token_stall is low, into the output register.
// ch_stall rises only while the queue is full, which happens when beats that make several
// tokens arrive faster than one token per cycle can leave, or when token_stall holds the
// output. Position saturates at MAX_LINE and sets overflow; EOF returns all lexer state to
// its reset values.
module shell_command_tokenizer_unit
    import sct_pkg::*;
#(
    parameter int MAX_LINE    = MAX_LINE_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ch_valid,
    output logic               ch_stall,
    input  logic [7:0]         ch,
    input  logic               end_of_input,
    output logic               token_valid,
    input  logic               token_stall,
    output logic [KIND_W-1:0]  token_kind,
    output logic [START_W-1:0] word_start,
    output logic [LEN_W-1:0]   word_length,
    output logic               overflow,
    output logic               last_of_run
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    run_t q_in;
    run_t q_head;

    sct_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .ch_valid     (ch_valid),
        .ch_stall     (ch_stall),
        .ch           (ch),
        .end_of_input (end_of_input),
        .q_full       (q_full),
        .push         (q_push),
        .run          (q_in)
    );

    sct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    sct_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (q_empty),
        .head        (q_head),
        .pop         (q_pop),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_kind  (token_kind),
        .word_start  (word_start),
        .word_length (word_length),
        .overflow    (overflow),
        .last_of_run (last_of_run)
    );

    a_eof_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind == TK_EOF |-> last_of_run)
        else $error("eof token not marked last of run");

    a_nonword_zero: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind != TK_WORD |-> word_start == '0 && word_length == '0)
        else $error("non-word token carries word fields");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("token queue written while full");

endmodule

FILE: tb/testbench.sv
module testbench;
    import sct_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int SHORT_BEATS = 370;

    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_NL     = 8'h0A;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_AMP    = 8'h26;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_LPAR   = 8'h28;
    localparam logic [7:0] C_RPAR   = 8'h29;
    localparam logic [7:0] C_ONE    = 8'h31;
    localparam logic [7:0] C_TWO    = 8'h32;
    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_LT     = 8'h3C;
    localparam logic [7:0] C_GT     = 8'h3E;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_PIPE   = 8'h7C;

    typedef enum int {
        LX_IDLE,
        LX_WORD,
        LX_PIPE,
        LX_AMP,
        LX_GT,
        LX_TWO,
        LX_ERR,
        LX_ERRAMP
    } lex_mode_e;

    typedef enum int {
        LINE_SHORT,
        LINE_LONG_WORD,
        LINE_LONG_MIX
    } line_shape_e;

    typedef struct {
        kind_t              kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        logic               ovf;
        logic               last;
    } token_t;

    // n < 0: tokens come from the lexer model
    typedef struct {
        logic [7:0] c;
        logic       eoi;
        int         n;
        kind_t      k0;
        kind_t      k1;
        kind_t      k2;
        int         ws;
        int         wl;
    } dir_row_t;

    dir_row_t dir_tab [29] = '{
        '{C_PIPE,   1'b0,  0, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{C_PIPE,   1'b0,  1, TK_OR,      TK_WORD,   TK_WORD,     0, 0},
        '{C_AMP,    1'b0,  0, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{C_AMP,    1'b0,  1, TK_AND,     TK_WORD,   TK_WORD,     0, 0},
        '{C_GT,     1'b0,  0, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{C_GT,     1'b0,  1, TK_APPEND,  TK_WORD,   TK_WORD,     0, 0},
        '{C_GT,     1'b0,  0, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{C_SEMI,   1'b0,  2, TK_OUT,     TK_SEMI,   TK_WORD,     0, 0},
        '{C_TWO,    1'b0,  0, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{C_GT,     1'b0,  0, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{C_AMP,    1'b0,  0, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{C_ONE,    1'b0,  1, TK_ERR_OUT, TK_WORD,   TK_WORD,     0, 0},
        '{C_TWO,    1'b0,  0, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{C_GT,     1'b0,  0, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{C_AMP,    1'b0,  0, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{C_LPAR,   1'b0,  3, TK_ERR,     TK_BG,     TK_LPAREN,   0, 0},
        '{C_NUL,    1'b0,  0, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{C_SQUOTE, 1'b0, -1, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{C_BSLASH, 1'b0, -1, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{C_SPACE,  1'b0, -1, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{C_SQUOTE, 1'b0, -1, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{8'hFF,    1'b0, -1, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{C_LT,     1'b0,  2, TK_WORD,    TK_IN,     TK_WORD,    16, 6},
        '{C_DQUOTE, 1'b0,  0, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{8'h5A,    1'b1,  2, TK_WORD,    TK_EOF,    TK_WORD,    23, 1},
        '{C_TWO,    1'b0,  0, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{C_RPAR,   1'b0,  2, TK_WORD,    TK_RPAREN, TK_WORD,     0, 1},
        '{C_PIPE,   1'b0,  0, TK_WORD,    TK_WORD,   TK_WORD,     0, 0},
        '{8'hA5,    1'b1,  2, TK_PIPE,    TK_EOF,    TK_WORD,     0, 0}
    };

    string op_text [13] = '{"|", "||", "&", "&&", "<", ">", ">>", "2>", "2>&1", "2>&",
                            ";", "(", ")"};
    string op_chars = "|&<>;()";

    logic               clk;
    logic               rst_n;
    logic               ch_valid;
    logic               ch_stall;
    logic [7:0]         ch;
    logic               end_of_input;
    logic               token_valid;
    logic               token_stall;
    logic [KIND_W-1:0]  token_kind;
    logic [START_W-1:0] word_start;
    logic [LEN_W-1:0]   word_length;
    logic               overflow;
    logic               last_of_run;

    // lexer model state
    lex_mode_e          lx_mode;
    logic [LEN_W-1:0]   lx_pos;
    logic [START_W-1:0] lx_begin;
    bit                 lx_sq;
    bit                 lx_dq;
    bit                 lx_esc;
    bit                 lx_ovf;

    token_t     beat_tokens [$];
    token_t     tokens_due [$];
    logic [7:0] line_q [$];

    int  typed_row = -1;
    bit  calm = 1'b0;
    int  stall_left = 0;
    int  stuck_cycles = 0;
    int  mismatches = 0;
    int  beats_in = 0;
    int  tokens_seen = 0;
    int  eof_seen = 0;
    int  ovf_seen = 0;
    int  short_beats = 0;

    shell_command_tokenizer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .ch_valid     (ch_valid),
        .ch_stall     (ch_stall),
        .ch           (ch),
        .end_of_input (end_of_input),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .token_kind   (token_kind),
        .word_start   (word_start),
        .word_length  (word_length),
        .overflow     (overflow),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void lex_clear();
        lx_mode  = LX_IDLE;
        lx_pos   = '0;
        lx_begin = '0;
        lx_sq    = 1'b0;
        lx_dq    = 1'b0;
        lx_esc   = 1'b0;
        lx_ovf   = 1'b0;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == C_SPACE || c == C_TAB || c == C_NL || c == C_CR;
    endfunction

    function automatic bit is_op(input logic [7:0] c);
        return c == C_PIPE || c == C_LT || c == C_GT || c == C_AMP || c == C_SEMI ||
               c == C_LPAR || c == C_RPAR;
    endfunction

    function automatic void put_op(input kind_t k);
        token_t t;
        t.kind  = k;
        t.start = '0;
        t.len   = '0;
        t.ovf   = lx_ovf;
        t.last  = 1'b0;
        beat_tokens.push_back(t);
    endfunction

    function automatic void put_word(input logic [LEN_W-1:0] stop);
        token_t t;
        t.kind  = TK_WORD;
        t.start = lx_begin;
        t.len   = (stop > {1'b0, lx_begin}) ? stop - {1'b0, lx_begin} : '0;
        t.ovf   = lx_ovf;
        t.last  = 1'b0;
        beat_tokens.push_back(t);
        lx_sq  = 1'b0;
        lx_dq  = 1'b0;
        lx_esc = 1'b0;
    endfunction

    // returns 0 when c ends the word
    function automatic bit word_char(input logic [7:0] c);
        if (lx_esc)
        begin
            lx_esc = 1'b0;
            return 1'b1;
        end
        if (lx_sq)
        begin
            if (c == C_SQUOTE)
                lx_sq = 1'b0;
            return 1'b1;
        end
        if (c == C_BSLASH)
        begin
            lx_esc = 1'b1;
            return 1'b1;
        end
        if (lx_dq)
        begin
            if (c == C_DQUOTE)
                lx_dq = 1'b0;
            return 1'b1;
        end
        if (c == C_SQUOTE)
        begin
            lx_sq = 1'b1;
            return 1'b1;
        end
        if (c == C_DQUOTE)
        begin
            lx_dq = 1'b1;
            return 1'b1;
        end
        return !(is_blank(c) || is_op(c));
    endfunction

    function automatic void lex_step(input logic [7:0] c, input logic eoi);
        logic [LEN_W-1:0]   cur;
        logic [START_W-1:0] off;
        bit                 done;
        beat_tokens.delete();
        if (eoi)
        begin
            case (lx_mode)
                LX_WORD, LX_TWO: put_word(lx_pos);
                LX_PIPE:         put_op(TK_PIPE);
                LX_AMP:          put_op(TK_BG);
                LX_GT:           put_op(TK_OUT);
                LX_ERR:          put_op(TK_ERR);
                LX_ERRAMP:
                begin
                    put_op(TK_ERR);
                    put_op(TK_BG);
                end
                default:         ;
            endcase
            put_op(TK_EOF);
            lex_clear();
            return;
        end
        cur = lx_pos;
        if (lx_pos < MAX_LINE_DEF)
            lx_pos = lx_pos + 1'b1;
        else
            lx_ovf = 1'b1;
        off = (cur < MAX_LINE_DEF) ? cur[START_W-1:0] : START_W'(MAX_LINE_DEF - 1);
        done = 1'b0;
        while (!done)
        begin
            case (lx_mode)
                LX_IDLE:
                begin
                    done = 1'b1;
                    if (!is_blank(c))
                    begin
                        if (c == C_PIPE)
                            lx_mode = LX_PIPE;
                        else if (c == C_AMP)
                            lx_mode = LX_AMP;
                        else if (c == C_GT)
                            lx_mode = LX_GT;
                        else if (c == C_LT)
                            put_op(TK_IN);
                        else if (c == C_SEMI)
                            put_op(TK_SEMI);
                        else if (c == C_LPAR)
                            put_op(TK_LPAREN);
                        else if (c == C_RPAR)
                            put_op(TK_RPAREN);
                        else if (c == C_TWO)
                        begin
                            lx_begin = off;
                            lx_mode = LX_TWO;
                        end
                        else
                        begin
                            lx_begin = off;
                            lx_mode = LX_WORD;
                            void'(word_char(c));
                        end
                    end
                end
                LX_WORD:
                begin
                    if (word_char(c))
                        done = 1'b1;
                    else
                    begin
                        put_word(cur);
                        lx_mode = LX_IDLE;
                    end
                end
                LX_PIPE:
                begin
                    lx_mode = LX_IDLE;
                    if (c == C_PIPE)
                    begin
                        put_op(TK_OR);
                        done = 1'b1;
                    end
                    else
                        put_op(TK_PIPE);
                end
                LX_AMP:
                begin
                    lx_mode = LX_IDLE;
                    if (c == C_AMP)
                    begin
                        put_op(TK_AND);
                        done = 1'b1;
                    end
                    else
                        put_op(TK_BG);
                end
                LX_GT:
                begin
                    lx_mode = LX_IDLE;
                    if (c == C_GT)
                    begin
                        put_op(TK_APPEND);
                        done = 1'b1;
                    end
                    else
                        put_op(TK_OUT);
                end
                LX_TWO:
                begin
                    if (c == C_GT)
                    begin
                        lx_mode = LX_ERR;
                        done = 1'b1;
                    end
                    else
                        lx_mode = LX_WORD;
                end
                LX_ERR:
                begin
                    if (c == C_AMP)
                    begin
                        lx_mode = LX_ERRAMP;
                        done = 1'b1;
                    end
                    else
                    begin
                        put_op(TK_ERR);
                        lx_mode = LX_IDLE;
                    end
                end
                LX_ERRAMP:
                begin
                    if (c == C_ONE)
                    begin
                        put_op(TK_ERR_OUT);
                        lx_mode = LX_IDLE;
                        done = 1'b1;
                    end
                    else
                    begin
                        put_op(TK_ERR);
                        lx_mode = LX_AMP;
                    end
                end
                default:
                    lx_mode = LX_IDLE;
            endcase
        end
    endfunction

    function automatic void load_typed(input dir_row_t r);
        kind_t  ks [3];
        token_t t;
        ks[0] = r.k0;
        ks[1] = r.k1;
        ks[2] = r.k2;
        beat_tokens.delete();
        for (int i = 0; i < r.n; i++)
        begin
            t.kind  = ks[i];
            t.start = (ks[i] == TK_WORD) ? START_W'(r.ws) : '0;
            t.len   = (ks[i] == TK_WORD) ? LEN_W'(r.wl) : '0;
            t.ovf   = 1'b0;
            t.last  = 1'b0;
            beat_tokens.push_back(t);
        end
    endfunction

    function automatic void check_field(input string what, input logic [LEN_W-1:0] want_v,
                                        input logic [LEN_W-1:0] got_v);
        if (want_v !== got_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [7:0] word_byte();
        case ($urandom_range(0, 11))
            0, 1:    return 8'(48 + $urandom_range(0, 9));
            2:       return 8'($urandom_range(128, 255));
            3:       return ($urandom_range(0, 1) == 0) ? C_NUL : C_TWO;
            default: return 8'(97 + $urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] quoted_byte();
        case ($urandom_range(0, 7))
            0:       return C_SPACE;
            1:       return C_BSLASH;
            2:       return op_chars[$urandom_range(0, op_chars.len() - 1)];
            3:       return ($urandom_range(0, 1) == 0) ? C_SQUOTE : C_DQUOTE;
            4:       return C_TAB;
            default: return word_byte();
        endcase
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endfunction

    function automatic void add_fragment();
        int n;
        int r;
        n = $urandom_range(1, 6);
        case ($urandom_range(0, 11))
            0, 1, 2, 3:
                repeat (n) line_q.push_back(word_byte());
            4, 5:
            begin
                line_q.push_back(($urandom_range(0, 1) == 0) ? C_SQUOTE : C_DQUOTE);
                r = line_q[line_q.size() - 1];
                repeat (n) line_q.push_back(quoted_byte());
                if ($urandom_range(0, 5) != 0)
                    line_q.push_back(8'(r));
            end
            6:
            begin
                line_q.push_back(C_BSLASH);
                line_q.push_back(8'($urandom_range(0, 255)));
            end
            7, 8:
                push_text(op_text[$urandom_range(0, 12)]);
            9:
            begin
                line_q.push_back(C_TWO);
                repeat (n - 1) line_q.push_back(word_byte());
            end
            10:
                line_q.push_back(8'($urandom_range(0, 255)));
            default:
            begin
                push_text(op_text[$urandom_range(0, 12)]);
                repeat (n) line_q.push_back(word_byte());
            end
        endcase
        r = $urandom_range(0, 9);
        if (r < 6)
            line_q.push_back(C_SPACE);
        else if (r == 6)
            line_q.push_back(C_TAB);
        else if (r == 7)
            line_q.push_back(C_NL);
        else if (r == 8)
            line_q.push_back(C_CR);
    endfunction

    task automatic send_beat(input logic [7:0] c, input logic eoi, input int row);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            ch_valid <= 1'b0;
            ch <= 8'($urandom_range(0, 255));
            repeat (gap) @(negedge clk);
        end
        typed_row = row;
        ch_valid <= 1'b1;
        ch <= c;
        end_of_input <= eoi;
        @(posedge clk);
        while (ch_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_line(input line_shape_e shape);
        line_q.delete();
        calm = ($urandom_range(0, 7) == 0);
        case (shape)
            LINE_LONG_WORD:
                repeat (MAX_LINE_DEF + 6) line_q.push_back(word_byte());
            LINE_LONG_MIX:
                while (line_q.size() < MAX_LINE_DEF + 40)
                    add_fragment();
            default:
                repeat ($urandom_range(1, 8)) add_fragment();
        endcase
        // long lines start from a fresh line
        if (shape != LINE_SHORT)
            send_beat(8'($urandom_range(0, 255)), 1'b1, -1);
        foreach (line_q[i])
            send_beat(line_q[i], 1'b0, -1);
        if (shape == LINE_SHORT)
            short_beats += line_q.size();
        if (shape != LINE_SHORT || $urandom_range(0, 6) != 0)
            send_beat(8'($urandom_range(0, 255)), 1'b1, -1);
        if ($urandom_range(0, 15) == 0)
            send_beat(8'($urandom_range(0, 255)), 1'b1, -1);
        calm = 1'b0;
    endtask

    // token sink back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            token_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            token_stall <= 1'b0;
            stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        token_t want;
        bit     moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (ch_valid && !ch_stall)
            begin
                moved = 1'b1;
                beats_in++;
                lex_step(ch, end_of_input);
                if (typed_row >= 0)
                    load_typed(dir_tab[typed_row]);
                foreach (beat_tokens[i])
                begin
                    want = beat_tokens[i];
                    want.last = (i == beat_tokens.size() - 1);
                    tokens_due.push_back(want);
                end
            end
            if (token_valid && !token_stall)
            begin
                moved = 1'b1;
                tokens_seen++;
                if (tokens_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected token: expected none, actual kind %0d", $time,
                             token_kind);
                end
                else
                begin
                    want = tokens_due.pop_front();
                    if (want.kind == TK_EOF)
                        eof_seen++;
                    if (want.ovf)
                        ovf_seen++;
                    check_field("token_kind", LEN_W'(want.kind), LEN_W'(token_kind));
                    check_field("word_start", LEN_W'(want.start), LEN_W'(word_start));
                    check_field("word_length", want.len, word_length);
                    check_field("overflow", LEN_W'(want.ovf), LEN_W'(overflow));
                    check_field("last_of_run", LEN_W'(want.last), LEN_W'(last_of_run));
                end
            end
            stuck_cycles = moved ? 0 : stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, STUCK_LIMIT);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int lines;
        rst_n = 1'b0;
        ch_valid = 1'b0;
        ch = '0;
        end_of_input = 1'b0;
        lex_clear();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[i])
            send_beat(dir_tab[i].c, dir_tab[i].eoi, (dir_tab[i].n >= 0) ? i : -1);

        lines = 0;
        while (short_beats < SHORT_BEATS)
        begin
            send_line(LINE_SHORT);
            lines++;
            // let the token queue drain completely now and then
            if (lines % 6 == 0)
            begin
                ch_valid <= 1'b0;
                do
                    @(negedge clk);
                while (tokens_due.size() != 0);
            end
        end

        ch_valid <= 1'b0;
        do
            @(posedge clk);
        while (tokens_due.size() != 0);
        repeat (8) @(posedge clk);

        $display("covered %0d input beats and %0d tokens over %0d lines", beats_in,
                 tokens_seen, lines);
        $display("%0d EOF tokens, %0d tokens with the line overflow flag set", eof_seen,
                 ovf_seen);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
